FILE: rtl/core/x86eu_pkg.sv
// Shared types and constants for the x86 subset execute unit.
// No dependencies; imported by the register file, the execute logic and the top level.
`default_nettype none

package x86eu_pkg;

    // Reset values of the architectural state
    localparam logic [15:0] FLAGS_RESET = 16'hF000;
    localparam logic [15:0] CS_RESET    = 16'hFFFF;

    // Flag bit positions in the flags word
    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 2;
    localparam int FLAG_ZF = 6;
    localparam int FLAG_SF = 7;
    localparam int FLAG_IF = 9;
    localparam int FLAG_OF = 11;

    // SAHF/LAHF masks
    localparam logic [15:0] SAHF_KEEP_MASK = 16'hFF2A;
    localparam logic [7:0]  AH_FLAG_MASK   = 8'hD5;
    localparam logic [7:0]  AH_KEEP_MASK   = 8'h2A;

    // ModRM fields
    localparam logic [7:0] MODRM_REG_MASK = 8'h38;
    localparam logic [7:0] MODRM_MOD_MASK = 8'hC0;
    localparam logic [2:0] SHIFT_SHL      = 3'd4;
    localparam logic [2:0] SHIFT_SHR      = 3'd5;

    // Register numbers in encoding order
    localparam logic [2:0] REG8_CL = 3'd1;
    localparam logic [2:0] REG8_AH = 3'd4;

    // Opcodes
    localparam logic [7:0] OP_JO       = 8'h70;
    localparam logic [7:0] OP_JNZ      = 8'h75;
    localparam logic [7:0] OP_JS       = 8'h78;
    localparam logic [7:0] OP_JNP      = 8'h7B;
    localparam logic [7:0] OP_SAHF     = 8'h9E;
    localparam logic [7:0] OP_LAHF     = 8'h9F;
    localparam logic [7:0] OP_MOV8_LO  = 8'hB0;
    localparam logic [7:0] OP_MOV8_HI  = 8'hB7;
    localparam logic [7:0] OP_MOV16_LO = 8'hB8;
    localparam logic [7:0] OP_MOV16_HI = 8'hBF;
    localparam logic [7:0] OP_SHIFT1   = 8'hD0;
    localparam logic [7:0] OP_SHIFTCL  = 8'hD2;
    localparam logic [7:0] OP_JMPF     = 8'hEA;
    localparam logic [7:0] OP_CLC      = 8'hF8;
    localparam logic [7:0] OP_STC      = 8'hF9;
    localparam logic [7:0] OP_CLI      = 8'hFA;

    // Jcc condition selectors (opcode bits 3:1)
    localparam logic [2:0] COND_O = 3'd0;
    localparam logic [2:0] COND_C = 3'd1;
    localparam logic [2:0] COND_Z = 3'd2;
    localparam logic [2:0] COND_S = 3'd4;

    typedef struct packed {
        logic        en;
        logic [2:0]  idx;
        logic        word;
        logic [15:0] value;
    } regwr_t;

    typedef struct packed {
        logic        status;
        logic [15:0] next_ip;
        logic [15:0] code_segment;
        logic [15:0] flags;
        logic [10:0] cycles;
        logic        jump_taken;
    } exres_t;

endpackage

`default_nettype wire

FILE: rtl/core/x86eu_regfile.sv
// General register file: eight 16-bit registers with byte and word access.
// Depends on x86eu_pkg for the register write type.
`default_nettype none

module x86eu_regfile (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            commit,
    input  x86eu_pkg::regwr_t    wr,
    input  wire logic [2:0]      sel,
    output logic [7:0]           ah,
    output logic [7:0]           cl,
    output logic [7:0]           src8
);
    import x86eu_pkg::*;

    logic [15:0] gpr_reg  [8];
    logic [15:0] gpr_next [8];

    assign ah   = gpr_reg[REG8_AH[1:0]][15:8];
    assign cl   = gpr_reg[REG8_CL[1:0]][7:0];
    assign src8 = sel[2] ? gpr_reg[sel[1:0]][15:8] : gpr_reg[sel[1:0]][7:0];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            gpr_next[i] = gpr_reg[i];
        end
        if (commit && wr.en)
        begin
            if (wr.word)
            begin
                gpr_next[wr.idx] = wr.value;
            end
            else if (wr.idx[2])
            begin
                gpr_next[{1'b0, wr.idx[1:0]}][15:8] = wr.value[7:0];
            end
            else
            begin
                gpr_next[{1'b0, wr.idx[1:0]}][7:0] = wr.value[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                gpr_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                gpr_reg[i] <= gpr_next[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/x86eu_exec.sv
// Single-pass decode and execute: jumps, moves, flag ops and 8-bit shifts.
// Depends on x86eu_pkg for opcodes, flag positions and result types.
`default_nettype none

module x86eu_exec (
    input  wire logic [7:0]        opcode_byte,
    input  wire logic [7:0]        second_byte,
    input  wire logic [7:0]        third_byte,
    input  wire logic [7:0]        fourth_byte,
    input  wire logic [7:0]        fifth_byte,
    input  wire logic              has_prefix,
    input  wire logic [15:0]       ip,
    input  wire logic [15:0]       cs,
    input  wire logic [15:0]       flags,
    input  wire logic [7:0]        ah,
    input  wire logic [7:0]        cl,
    input  wire logic [7:0]        src8,
    output logic [2:0]             sel,
    output x86eu_pkg::exres_t      res,
    output x86eu_pkg::regwr_t      wr
);
    import x86eu_pkg::*;

    logic [7:0]  count;
    logic [7:0]  count_m1;
    logic        count_big;
    logic        is_shr;
    logic        shift_ok;
    logic [7:0]  shl_tmp;
    logic [7:0]  shr_tmp;
    logic [7:0]  sh_res;
    logic        sh_cf;
    logic        sh_of;
    logic        cond;
    logic [2:0]  len;

    assign sel = second_byte[2:0];

    // 8-bit shift datapath; a count of nine or more flushes everything out
    always_comb
    begin
        count     = (opcode_byte == OP_SHIFT1) ? 8'd1 : cl;
        count_m1  = count - 8'd1;
        count_big = |count_m1[7:3];
        is_shr    = ((second_byte & MODRM_REG_MASK) >> 3) == {5'b0, SHIFT_SHR};
        shift_ok  = ((second_byte & MODRM_MOD_MASK) == MODRM_MOD_MASK)
                    && (second_byte[5:3] == SHIFT_SHL || second_byte[5:3] == SHIFT_SHR);
        shl_tmp   = count_big ? 8'h00 : (src8 << count_m1[2:0]);
        shr_tmp   = count_big ? 8'h00 : (src8 >> count_m1[2:0]);
        if (is_shr)
        begin
            sh_res = {1'b0, shr_tmp[7:1]};
            sh_cf  = shr_tmp[0];
            sh_of  = src8[7];
        end
        else
        begin
            sh_res = {shl_tmp[6:0], 1'b0};
            sh_cf  = shl_tmp[7];
            sh_of  = src8[7] ^ shl_tmp[7];
        end
    end

    always_comb
    begin
        res.status       = 1'b0;
        res.next_ip      = ip;
        res.code_segment = cs;
        res.flags        = flags;
        res.cycles       = '0;
        res.jump_taken   = 1'b0;
        wr               = '0;
        len              = 3'd1;
        cond             = 1'b0;

        unique case (opcode_byte) inside
            [OP_JO:OP_JNZ], [OP_JS:OP_JNP]:
            begin
                case (opcode_byte[3:1])
                    COND_O:  cond = flags[FLAG_OF];
                    COND_C:  cond = flags[FLAG_CF];
                    COND_Z:  cond = flags[FLAG_ZF];
                    COND_S:  cond = flags[FLAG_SF];
                    default: cond = flags[FLAG_PF];
                endcase
                cond       = cond ^ opcode_byte[0];
                len        = 3'd2;
                res.cycles = 11'd4;
                if (cond)
                begin
                    // target is the end of the instruction, prefix included, plus the displacement
                    res.next_ip    = ip + 16'd2 + {15'b0, has_prefix}
                                     + {{8{second_byte[7]}}, second_byte};
                    res.cycles     = 11'd16;
                    res.jump_taken = 1'b1;
                end
            end
            OP_SAHF:
            begin
                res.flags  = (flags & SAHF_KEEP_MASK) | {8'h00, ah & AH_FLAG_MASK};
                res.cycles = 11'd4;
            end
            OP_LAHF:
            begin
                wr.en      = 1'b1;
                wr.idx     = REG8_AH;
                wr.value   = {8'h00, (ah & AH_KEEP_MASK) | (flags[7:0] & AH_FLAG_MASK)};
                res.cycles = 11'd4;
            end
            [OP_MOV8_LO:OP_MOV8_HI]:
            begin
                wr.en      = 1'b1;
                wr.idx     = opcode_byte[2:0];
                wr.value   = {8'h00, second_byte};
                len        = 3'd2;
                res.cycles = 11'd4;
            end
            [OP_MOV16_LO:OP_MOV16_HI]:
            begin
                wr.en      = 1'b1;
                wr.idx     = opcode_byte[2:0];
                wr.word    = 1'b1;
                wr.value   = {third_byte, second_byte};
                len        = 3'd3;
                res.cycles = 11'd4;
            end
            OP_SHIFT1, OP_SHIFTCL:
            begin
                if (shift_ok)
                begin
                    wr.en  = 1'b1;
                    wr.idx = second_byte[2:0];
                    len    = 3'd2;
                    if (count == 8'd0)
                    begin
                        // zero count: clear OF, write the operand back
                        res.flags[FLAG_OF] = 1'b0;
                        wr.value           = {8'h00, src8};
                    end
                    else
                    begin
                        res.flags[FLAG_OF] = sh_of;
                        res.flags[FLAG_CF] = sh_cf;
                        res.flags[FLAG_ZF] = (sh_res == 8'h00);
                        res.flags[FLAG_SF] = sh_res[7];
                        res.flags[FLAG_PF] = ~(^sh_res);
                        wr.value           = {8'h00, sh_res};
                    end
                    if (opcode_byte == OP_SHIFT1)
                    begin
                        res.cycles = 11'd2;
                    end
                    else
                    begin
                        res.cycles = 11'd8 + {1'b0, count, 2'b00};
                    end
                end
                else
                begin
                    res.status = 1'b1;
                end
            end
            OP_JMPF:
            begin
                res.next_ip      = {third_byte, second_byte};
                res.code_segment = {fifth_byte, fourth_byte};
                res.jump_taken   = 1'b1;
                res.cycles       = 11'd15;
            end
            OP_CLC:
            begin
                res.flags[FLAG_CF] = 1'b0;
                res.cycles         = 11'd2;
            end
            OP_STC:
            begin
                res.flags[FLAG_CF] = 1'b1;
                res.cycles         = 11'd2;
            end
            OP_CLI:
            begin
                res.flags[FLAG_IF] = 1'b0;
                res.cycles         = 11'd2;
            end
            default:
            begin
                res.status = 1'b1;
            end
        endcase

        if (!res.status && !res.jump_taken)
        begin
            res.next_ip = ip + {13'b0, len} + {15'b0, has_prefix};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/x86_subset_execute_unit.sv
// Channel | Direction | Fields
// in      | input     | opcode_byte, second_byte .. fifth_byte, has_prefix
// out     | output    | status, next_ip, code_segment, flags_out, cycle_count,
//         |           | jump_taken, reg_write, reg_index, reg_is_word, reg_value
//
// One instruction per clock sustained while out is not stalled. The execute logic runs
// in one pass between the input register and the result register, and out_valid rises
// and the architectural state commits as the item enters the result register.
// Reset gives ip 0, cs 0xFFFF, flags 0xF000 and all general registers 0.
// A stall on out holds the result and back-pressures in only once both stages are full.
// Top level of the x86 subset execute unit; uses x86eu_pkg, x86eu_regfile and x86eu_exec.
`default_nettype none

module x86_subset_execute_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  opcode_byte,
    input  wire logic [7:0]  second_byte,
    input  wire logic [7:0]  third_byte,
    input  wire logic [7:0]  fourth_byte,
    input  wire logic [7:0]  fifth_byte,
    input  wire logic        has_prefix,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             status,
    output logic [15:0]      next_ip,
    output logic [15:0]      code_segment,
    output logic [15:0]      flags_out,
    output logic [10:0]      cycle_count,
    output logic             jump_taken,
    output logic             reg_write,
    output logic [2:0]       reg_index,
    output logic             reg_is_word,
    output logic [15:0]      reg_value
);
    import x86eu_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  op_reg, b1_reg, b2_reg, b3_reg, b4_reg;
    logic        pre_reg;

    logic [15:0] ip_reg, ip_next;
    logic [15:0] cs_reg, cs_next;
    logic [15:0] flags_reg, flags_next;

    logic        out_valid_reg, out_valid_next;
    exres_t      res_reg;
    regwr_t      wr_reg;

    logic        advance;
    logic [2:0]  sel;
    logic [7:0]  ah, cl, src8;
    exres_t      res;
    regwr_t      wr;

    // advance when the result register is empty or being drained
    assign advance  = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;

    x86eu_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .wr     (wr),
        .sel    (sel),
        .ah     (ah),
        .cl     (cl),
        .src8   (src8)
    );

    x86eu_exec u_exec (
        .opcode_byte (op_reg),
        .second_byte (b1_reg),
        .third_byte  (b2_reg),
        .fourth_byte (b3_reg),
        .fifth_byte  (b4_reg),
        .has_prefix  (pre_reg),
        .ip          (ip_reg),
        .cs          (cs_reg),
        .flags       (flags_reg),
        .ah          (ah),
        .cl          (cl),
        .src8        (src8),
        .sel         (sel),
        .res         (res),
        .wr          (wr)
    );

    always_comb
    begin
        s1_valid_next = in_stall ? s1_valid_reg : in_valid;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
        ip_next    = advance ? res.next_ip      : ip_reg;
        cs_next    = advance ? res.code_segment : cs_reg;
        flags_next = advance ? res.flags        : flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ip_reg        <= '0;
            cs_reg        <= CS_RESET;
            flags_reg     <= FLAGS_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            ip_reg        <= ip_next;
            cs_reg        <= cs_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg  <= opcode_byte;
            b1_reg  <= second_byte;
            b2_reg  <= third_byte;
            b3_reg  <= fourth_byte;
            b4_reg  <= fifth_byte;
            pre_reg <= has_prefix;
        end
        if (advance)
        begin
            res_reg <= res;
            wr_reg  <= wr;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = res_reg.status;
    assign next_ip      = res_reg.next_ip;
    assign code_segment = res_reg.code_segment;
    assign flags_out    = res_reg.flags;
    assign cycle_count  = res_reg.cycles;
    assign jump_taken   = res_reg.jump_taken;
    assign reg_write    = wr_reg.en;
    assign reg_index    = wr_reg.idx;
    assign reg_is_word  = wr_reg.word;
    assign reg_value    = wr_reg.value;

    // an unimplemented instruction leaves no trace beyond its status
    a_unimpl_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.status)
        |-> (!wr_reg.en && !res_reg.jump_taken && res_reg.cycles == 11'd0))
        else $error("unimplemented instruction produced side effects");

    // an executed instruction always costs cycles
    a_exec_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.status) |-> (res_reg.cycles != 11'd0))
        else $error("executed instruction reported zero cycles");

    // no register write means a zeroed write report
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !wr_reg.en)
        |-> (wr_reg.idx == 3'd0 && !wr_reg.word && wr_reg.value == 16'd0))
        else $error("write report not cleared without a register write");

    // committed state matches the reported result
    a_state_commit: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (flags_reg == res_reg.flags && ip_reg == res_reg.next_ip
                     && cs_reg == res_reg.code_segment))
        else $error("architectural state diverged from reported result");

    // back-pressure only when both stages hold an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire

FILE: bench/x86_subset_execute_unit_tb.sv
// Self-checking bench for x86_subset_execute_unit: directed table, then random instruction mix.
// Keeps its own copy of registers, flags, ip and cs to predict every result; needs x86eu_pkg.
module x86_subset_execute_unit_tb;

    import x86eu_pkg::*;

    localparam int          NUM_DIRECTED = 25;
    localparam int          NUM_RANDOM   = 1100;
    localparam int          LONG_HOLD    = 80;
    localparam int          SETTLE       = 8;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_UNIMPL = 1'b1;

    // Opcodes outside the executed set, plus a few Jcc encodings used by name
    localparam logic [7:0] OP_NOP       = 8'h90;
    localparam logic [7:0] OP_GRP5      = 8'hFF;
    localparam logic [7:0] OP_SHIFT1_W  = 8'hD1;
    localparam logic [7:0] OP_JNO       = 8'h71;
    localparam logic [7:0] OP_JB        = 8'h72;

    localparam logic [2:0] REG8_AL   = 3'd0;
    localparam logic [2:0] REG8_BH   = 3'd7;
    localparam logic [2:0] REG16_SP  = 3'd4;
    localparam logic [2:0] SHIFT_ROL = 3'd0;

    typedef struct packed {
        logic [7:0] op;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic       prefix;
    } instr_t;

    typedef struct packed {
        exres_t ex;
        regwr_t wr;
    } retire_t;

    typedef struct packed {
        bit      pinned;
        instr_t  ins;
        retire_t want;
    } dir_row_t;

    localparam retire_t NO_PIN = '0;

    localparam logic [7:0] MODRM_SHL_AL = MODRM_MOD_MASK | {2'b00, SHIFT_SHL, REG8_AL};
    localparam logic [7:0] MODRM_SHR_AL = MODRM_MOD_MASK | {2'b00, SHIFT_SHR, REG8_AL};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  opcode_byte;
    logic [7:0]  second_byte;
    logic [7:0]  third_byte;
    logic [7:0]  fourth_byte;
    logic [7:0]  fifth_byte;
    logic        has_prefix;
    logic        out_valid;
    logic        out_stall;
    logic        status;
    logic [15:0] next_ip;
    logic [15:0] code_segment;
    logic [15:0] flags_out;
    logic [10:0] cycle_count;
    logic        jump_taken;
    logic        reg_write;
    logic [2:0]  reg_index;
    logic        reg_is_word;
    logic [15:0] reg_value;

    // Architectural state as the bench sees it
    logic [15:0] arch_regs [8];
    logic [15:0] arch_flags;
    logic [15:0] arch_ip;
    logic [15:0] arch_cs;

    retire_t     retire_queue [$];
    int          mismatch_count = 0;
    int          checked_no = 0;
    int          issued_no = 0;
    int          transfers_no = 0;
    int          writes_no = 0;
    int          unimpl_no = 0;
    bit          long_hold_req = 1'b0;
    int unsigned cycle_no = 0;

    // Pinned rows carry a result that follows directly from reset or the encoding
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        {1'b1, OP_NOP, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
         STATUS_UNIMPL, 16'h0000, CS_RESET, FLAGS_RESET, 11'd0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
        {1'b1, OP_GRP5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
         STATUS_UNIMPL, 16'h0000, CS_RESET, FLAGS_RESET, 11'd0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000},
        {1'b1, OP_JMPF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
         STATUS_DONE, 16'hFFFF, 16'hFFFF, FLAGS_RESET, 11'd15, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000},
        {1'b1, OP_MOV16_LO | {5'd0, REG16_SP}, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1,
         STATUS_DONE, 16'h0003, 16'hFFFF, FLAGS_RESET, 11'd4, 1'b0, 1'b1, REG16_SP, 1'b1, 16'hFFFF},
        {1'b0, OP_MOV8_LO | {5'd0, REG8_AH}, 8'hD5, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_SAHF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_LAHF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_JNO, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1, NO_PIN},
        {1'b0, OP_JB, 8'h7F, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_JNZ, 8'h10, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_STC, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_CLC, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_CLI, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_MOV8_LO | {5'd0, REG8_CL}, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_SHIFTCL, MODRM_SHL_AL, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_MOV8_LO | {5'd0, REG8_AL}, 8'h81, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_SHIFT1, MODRM_SHL_AL, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_SHIFT1, MODRM_SHR_AL, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_MOV8_LO | {5'd0, REG8_CL}, 8'h09, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_SHIFTCL, MODRM_SHR_AL, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_MOV8_LO | {5'd0, REG8_CL}, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_SHIFTCL, MODRM_MOD_MASK | {2'b00, SHIFT_SHL, REG8_BH}, 8'h00, 8'h00, 8'h00,
         1'b0, NO_PIN},
        {1'b0, OP_SHIFT1, {2'b00, SHIFT_SHL, REG8_AL}, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN},
        {1'b0, OP_SHIFT1, MODRM_MOD_MASK | {2'b00, SHIFT_ROL, REG8_AL}, 8'h00, 8'h00, 8'h00,
         1'b0, NO_PIN},
        {1'b0, OP_SHIFT1_W, MODRM_SHL_AL, 8'h00, 8'h00, 8'h00, 1'b0, NO_PIN}
    };

    x86_subset_execute_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode_byte  (opcode_byte),
        .second_byte  (second_byte),
        .third_byte   (third_byte),
        .fourth_byte  (fourth_byte),
        .fifth_byte   (fifth_byte),
        .has_prefix   (has_prefix),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .next_ip      (next_ip),
        .code_segment (code_segment),
        .flags_out    (flags_out),
        .cycle_count  (cycle_count),
        .jump_taken   (jump_taken),
        .reg_write    (reg_write),
        .reg_index    (reg_index),
        .reg_is_word  (reg_is_word),
        .reg_value    (reg_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] get_r8(input logic [2:0] idx);
        return idx[2] ? arch_regs[idx[1:0]][15:8] : arch_regs[idx[1:0]][7:0];
    endfunction

    function automatic void put_r8(input logic [2:0] idx, input logic [7:0] val);
        if (idx[2])
            arch_regs[idx[1:0]][15:8] = val;
        else
            arch_regs[idx[1:0]][7:0] = val;
    endfunction

    // Execute one instruction against the bench state and return what should retire
    function automatic retire_t retire_instruction(input instr_t ins);
        retire_t     r;
        logic        taken;
        logic [2:0]  rm;
        logic [7:0]  src;
        logic [7:0]  tmp;
        logic [7:0]  res;
        logic [15:0] len;
        int          count;
        r = '0;
        len = 16'd1;
        if ((ins.op >= OP_JO && ins.op <= OP_JNZ) || (ins.op >= OP_JS && ins.op <= OP_JNP))
        begin
            case (ins.op[3:1])
                COND_O:  taken = arch_flags[FLAG_OF];
                COND_C:  taken = arch_flags[FLAG_CF];
                COND_Z:  taken = arch_flags[FLAG_ZF];
                COND_S:  taken = arch_flags[FLAG_SF];
                default: taken = arch_flags[FLAG_PF];
            endcase
            taken = taken ^ ins.op[0];
            len = 16'd2;
            r.ex.cycles = 11'd4;
            if (taken)
            begin
                // target is the end of the instruction, prefix included, plus displacement
                arch_ip = arch_ip + 16'd2 + {15'd0, ins.prefix} + {{8{ins.b1[7]}}, ins.b1};
                r.ex.cycles = 11'd16;
                r.ex.jump_taken = 1'b1;
            end
        end
        else if (ins.op == OP_SAHF)
        begin
            arch_flags = (arch_flags & SAHF_KEEP_MASK) | {8'h00, get_r8(REG8_AH) & AH_FLAG_MASK};
            r.ex.cycles = 11'd4;
        end
        else if (ins.op == OP_LAHF)
        begin
            src = (get_r8(REG8_AH) & AH_KEEP_MASK) | (arch_flags[7:0] & AH_FLAG_MASK);
            put_r8(REG8_AH, src);
            r.wr = '{en: 1'b1, idx: REG8_AH, word: 1'b0, value: {8'h00, src}};
            r.ex.cycles = 11'd4;
        end
        else if (ins.op >= OP_MOV8_LO && ins.op <= OP_MOV8_HI)
        begin
            put_r8(ins.op[2:0], ins.b1);
            r.wr = '{en: 1'b1, idx: ins.op[2:0], word: 1'b0, value: {8'h00, ins.b1}};
            len = 16'd2;
            r.ex.cycles = 11'd4;
        end
        else if (ins.op >= OP_MOV16_LO && ins.op <= OP_MOV16_HI)
        begin
            arch_regs[ins.op[2:0]] = {ins.b2, ins.b1};
            r.wr = '{en: 1'b1, idx: ins.op[2:0], word: 1'b1, value: {ins.b2, ins.b1}};
            len = 16'd3;
            r.ex.cycles = 11'd4;
        end
        else if ((ins.op == OP_SHIFT1 || ins.op == OP_SHIFTCL)
                 && (ins.b1 & MODRM_MOD_MASK) == MODRM_MOD_MASK
                 && (ins.b1[5:3] == SHIFT_SHL || ins.b1[5:3] == SHIFT_SHR))
        begin
            count = (ins.op == OP_SHIFT1) ? 1 : int'(get_r8(REG8_CL));
            rm = ins.b1[2:0];
            src = get_r8(rm);
            if (count == 0)
            begin
                // zero count: only OF is cleared, operand written back as it was
                arch_flags[FLAG_OF] = 1'b0;
                res = src;
            end
            else
            begin
                if (ins.b1[5:3] == SHIFT_SHL)
                begin
                    tmp = (count > 8) ? 8'h00 : src << (count - 1);
                    arch_flags[FLAG_OF] = src[7] ^ tmp[7];
                    arch_flags[FLAG_CF] = tmp[7];
                    res = tmp << 1;
                end
                else
                begin
                    tmp = (count > 8) ? 8'h00 : src >> (count - 1);
                    arch_flags[FLAG_OF] = src[7];
                    arch_flags[FLAG_CF] = tmp[0];
                    res = tmp >> 1;
                end
                arch_flags[FLAG_ZF] = (res == 8'h00);
                arch_flags[FLAG_SF] = res[7];
                arch_flags[FLAG_PF] = ~^res;
            end
            put_r8(rm, res);
            r.wr = '{en: 1'b1, idx: rm, word: 1'b0, value: {8'h00, res}};
            len = 16'd2;
            r.ex.cycles = (ins.op == OP_SHIFT1) ? 11'd2 : 11'(8 + 4 * count);
        end
        else if (ins.op == OP_JMPF)
        begin
            arch_ip = {ins.b2, ins.b1};
            arch_cs = {ins.b4, ins.b3};
            r.ex.jump_taken = 1'b1;
            r.ex.cycles = 11'd15;
        end
        else if (ins.op == OP_CLC)
        begin
            arch_flags[FLAG_CF] = 1'b0;
            r.ex.cycles = 11'd2;
        end
        else if (ins.op == OP_STC)
        begin
            arch_flags[FLAG_CF] = 1'b1;
            r.ex.cycles = 11'd2;
        end
        else if (ins.op == OP_CLI)
        begin
            arch_flags[FLAG_IF] = 1'b0;
            r.ex.cycles = 11'd2;
        end
        else
        begin
            r.ex.status = STATUS_UNIMPL;
        end
        if (r.ex.status == STATUS_DONE && !r.ex.jump_taken)
            arch_ip = arch_ip + len + {15'd0, ins.prefix};
        r.ex.next_ip = arch_ip;
        r.ex.code_segment = arch_cs;
        r.ex.flags = arch_flags;
        return r;
    endfunction

    // Mostly well-formed instructions with random content, the rest noise
    function automatic instr_t random_instr();
        instr_t ins;
        int     pick;
        int     k;
        ins.op = 8'($urandom);
        ins.b1 = 8'($urandom);
        ins.b2 = 8'($urandom);
        ins.b3 = 8'($urandom);
        ins.b4 = 8'($urandom);
        ins.prefix = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 24)
        begin
            k = $urandom_range(0, 9);
            ins.op = (k < 6) ? OP_JO + 8'(k) : OP_JS + 8'(k - 6);
        end
        else if (pick < 38)
        begin
            ins.op = OP_MOV8_LO + 8'($urandom_range(0, 7));
            // keep CL mostly small so shifts by CL hit every count up to past eight
            if (ins.op[2:0] == REG8_CL && $urandom_range(0, 3) != 0)
                ins.b1 = 8'($urandom_range(0, 10));
        end
        else if (pick < 46)
            ins.op = OP_MOV16_LO + 8'($urandom_range(0, 7));
        else if (pick < 66)
        begin
            ins.op = $urandom_range(0, 1) ? OP_SHIFT1 : OP_SHIFTCL;
            ins.b1 = MODRM_MOD_MASK
                     | {2'b00, ($urandom_range(0, 1) ? SHIFT_SHR : SHIFT_SHL),
                        3'($urandom_range(0, 7))};
        end
        else if (pick < 74)
            ins.op = $urandom_range(0, 1) ? OP_SAHF : OP_LAHF;
        else if (pick < 82)
        begin
            k = $urandom_range(0, 2);
            ins.op = (k == 0) ? OP_CLC : (k == 1) ? OP_STC : OP_CLI;
        end
        else if (pick < 86)
            ins.op = OP_JMPF;
        else if (pick < 94)
            ins.op = OP_SHIFT1 + 8'($urandom_range(0, 3));
        return ins;
    endfunction

    // Wait before the next item, drawn at random, with occasional runs of back-to-back items
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm_left = $urandom_range(15, 50);
        return $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < 40)
            $display("MISMATCH result %0d %s: got 0x%h, expected 0x%h",
                     checked_no, what, got, want);
        mismatch_count++;
    endtask

    task automatic offer(input instr_t ins, input int gap, input bit pinned, input retire_t want);
        retire_t predicted;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode_byte <= ins.op;
        second_byte <= ins.b1;
        third_byte  <= ins.b2;
        fourth_byte <= ins.b3;
        fifth_byte  <= ins.b4;
        has_prefix  <= ins.prefix;
        do
            @(posedge clk);
        while (in_stall);
        predicted = retire_instruction(ins);
        retire_queue.push_back(pinned ? want : predicted);
        issued_no++;
        if (predicted.ex.jump_taken)
            transfers_no++;
        if (predicted.wr.en)
            writes_no++;
        if (predicted.ex.status == STATUS_UNIMPL)
            unimpl_no++;
    endtask

    task automatic pause_until_retired();
        in_valid <= 1'b0;
        while (retire_queue.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : instruction_feed
        int send_calm;
        int gap;
        send_calm = 0;
        for (int i = 0; i < 8; i++)
            arch_regs[i] = 16'h0000;
        arch_flags = FLAGS_RESET;
        arch_ip = 16'h0000;
        arch_cs = CS_RESET;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        opcode_byte <= 8'h00;
        second_byte <= 8'h00;
        third_byte  <= 8'h00;
        fourth_byte <= 8'h00;
        fifth_byte  <= 8'h00;
        has_prefix  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < NUM_DIRECTED; i++)
            offer(directed_rows[i].ins, draw_wait(send_calm), directed_rows[i].pinned,
                  directed_rows[i].want);
        pause_until_retired();
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            // flood the block while the output side holds off, so that it backs up
            if (i == 300)
                long_hold_req = 1'b1;
            if (i == 700)
                pause_until_retired();
            gap = (i >= 300 && i < 340) ? 0 : draw_wait(send_calm);
            offer(random_instr(), gap, 1'b0, NO_PIN);
        end
        pause_until_retired();
        repeat (SETTLE) @(posedge clk);
        $display("Executed %0d instructions: %0d control transfers, %0d register writes, "
                 , issued_no, transfers_no, writes_no,
                 "%0d unimplemented", unimpl_no);
        $display("Checked %0d results, %0d field mismatches", checked_no, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : result_sink
        int take_calm;
        int hold;
        take_calm = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else
                hold = draw_wait(take_calm);
            out_stall <= (hold != 0);
            repeat (hold) @(posedge clk);
            if (hold != 0)
                out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        retire_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (retire_queue.size() == 0)
                report_mismatch("result with nothing outstanding", next_ip, 16'h0000);
            else
            begin
                want = retire_queue.pop_front();
                if (status !== want.ex.status)
                    report_mismatch("status", 16'(status), 16'(want.ex.status));
                if (next_ip !== want.ex.next_ip)
                    report_mismatch("next_ip", next_ip, want.ex.next_ip);
                if (code_segment !== want.ex.code_segment)
                    report_mismatch("code_segment", code_segment, want.ex.code_segment);
                if (flags_out !== want.ex.flags)
                    report_mismatch("flags_out", flags_out, want.ex.flags);
                if (cycle_count !== want.ex.cycles)
                    report_mismatch("cycle_count", 16'(cycle_count), 16'(want.ex.cycles));
                if (jump_taken !== want.ex.jump_taken)
                    report_mismatch("jump_taken", 16'(jump_taken), 16'(want.ex.jump_taken));
                if (reg_write !== want.wr.en)
                    report_mismatch("reg_write", 16'(reg_write), 16'(want.wr.en));
                if (reg_index !== want.wr.idx)
                    report_mismatch("reg_index", 16'(reg_index), 16'(want.wr.idx));
                if (reg_is_word !== want.wr.word)
                    report_mismatch("reg_is_word", 16'(reg_is_word), 16'(want.wr.word));
                if (reg_value !== want.wr.value)
                    report_mismatch("reg_value", reg_value, want.wr.value);
            end
            checked_no++;
        end
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT)
        begin
            $display("Timed out with %0d results outstanding", retire_queue.size());
            $display("Verification failed");
            $finish;
        end
    end

endmodule

FILE: x86_subset_execute_unit.f
rtl/core/x86eu_pkg.sv
rtl/core/x86eu_regfile.sv
rtl/core/x86eu_exec.sv
rtl/core/x86_subset_execute_unit.sv
bench/x86_subset_execute_unit_tb.sv
